// File: design/odf_pkg.sv
// shared types, constants and register codes for the octave divider effect
`default_nettype none

package odf_pkg;

    // channel count and index width
    localparam int CHANNELS = 2;
    localparam int CH_W     = 1;

    // sample, envelope and coefficient widths
    localparam int SAMPLE_W = 16;
    localparam int ENV_W    = 17;
    localparam int COEFF_W  = 16;

    // configuration register indexes
    localparam logic [1:0] REG_OCTAVE_MODE   = 2'd0;
    localparam logic [1:0] REG_ATTACK_COEFF  = 2'd1;
    localparam logic [1:0] REG_RELEASE_COEFF = 2'd2;

    // octave mode codes
    localparam logic [1:0] MODE_DOWN = 2'd0;
    localparam logic [1:0] MODE_OFF  = 2'd1;
    localparam logic [1:0] MODE_UP   = 2'd2;

    // reset values of the configuration registers
    localparam logic [1:0]         RESET_MODE    = MODE_OFF;
    localparam logic [COEFF_W-1:0] RESET_ATTACK  = 16'd655;
    localparam logic [COEFF_W-1:0] RESET_RELEASE = 16'd66;

    // configuration seen by the datapath
    typedef struct packed {
        logic [1:0]         octave_mode;
        logic [COEFF_W-1:0] attack_coeff;
        logic [COEFF_W-1:0] release_coeff;
    } t_cfg;

    // magnitude of a signed sample, 0..32768
    function automatic logic [SAMPLE_W-1:0] abs_sample(input logic [SAMPLE_W-1:0] x);
        abs_sample = x[SAMPLE_W-1] ? (SAMPLE_W'(0) - x) : x;
    endfunction

endpackage

`default_nettype wire

// File: design/odf_cfg.sv
// configuration registers of the octave divider effect
`default_nettype none

module odf_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [1:0]                    i_cfg_idx,
    input  wire logic [odf_pkg::COEFF_W-1:0]   i_cfg_wdata,
    output odf_pkg::t_cfg                      o_cfg
);

    logic [1:0]                  r_mode;
    logic [odf_pkg::COEFF_W-1:0] r_attack;
    logic [odf_pkg::COEFF_W-1:0] r_release;

    // register writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= odf_pkg::RESET_MODE;
            r_attack  <= odf_pkg::RESET_ATTACK;
            r_release <= odf_pkg::RESET_RELEASE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                odf_pkg::REG_OCTAVE_MODE:   r_mode    <= i_cfg_wdata[1:0];
                odf_pkg::REG_ATTACK_COEFF:  r_attack  <= i_cfg_wdata;
                odf_pkg::REG_RELEASE_COEFF: r_release <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg.octave_mode   = r_mode;
    assign o_cfg.attack_coeff  = r_attack;
    assign o_cfg.release_coeff = r_release;

endmodule

`default_nettype wire

// File: design/odf_down.sv
// per-channel flip-flop divider and envelope follower for octave-down mode
`default_nettype none

module odf_down (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_update,
    input  wire logic [odf_pkg::CH_W-1:0]      i_ch,
    input  wire logic [odf_pkg::SAMPLE_W-1:0]  i_sample,
    input  wire odf_pkg::t_cfg                 i_cfg,
    output logic      [odf_pkg::SAMPLE_W-1:0]  o_sample
);

    localparam int PROD_W = odf_pkg::COEFF_W + odf_pkg::ENV_W;

    logic                       r_last_neg [odf_pkg::CHANNELS];
    logic                       r_cross    [odf_pkg::CHANNELS];
    logic                       r_flip     [odf_pkg::CHANNELS];
    logic [odf_pkg::ENV_W-1:0]  r_env      [odf_pkg::CHANNELS];

    logic                          neg;
    logic [odf_pkg::SAMPLE_W-1:0]  mag;
    logic [odf_pkg::ENV_W-1:0]     target;
    logic [odf_pkg::ENV_W-1:0]     env;
    logic                          rise;
    logic [odf_pkg::ENV_W-1:0]     diff;
    logic [odf_pkg::COEFF_W-1:0]   coeff;
    logic [PROD_W-1:0]             prod;
    logic [odf_pkg::ENV_W-1:0]     delta;
    logic [odf_pkg::ENV_W-1:0]     n_env;
    logic                          n_cross;
    logic                          n_flip;
    logic [odf_pkg::SAMPLE_W-1:0]  mag_out;

    // envelope step toward twice the sample magnitude
    always_comb begin
        neg    = i_sample[odf_pkg::SAMPLE_W-1];
        mag    = odf_pkg::abs_sample(i_sample);
        target = {mag, 1'b0};
        env    = r_env[i_ch];
        rise   = target > env;
        diff   = rise ? (target - env) : (env - target);
        coeff  = rise ? i_cfg.attack_coeff : i_cfg.release_coeff;
        prod   = PROD_W'(coeff) * PROD_W'(diff);
        delta  = prod[PROD_W-1:odf_pkg::COEFF_W];
        n_env  = rise ? (env + delta) : (env - delta);
    end

    // zero crossing count, sign toggles every second crossing
    always_comb begin
        n_cross = r_cross[i_ch];
        n_flip  = r_flip[i_ch];
        if (neg != r_last_neg[i_ch]) begin
            if (r_cross[i_ch]) begin
                n_flip  = ~r_flip[i_ch];
                n_cross = 1'b0;
            end else begin
                n_cross = 1'b1;
            end
        end
    end

    // signed envelope with positive full scale saturated
    always_comb begin
        mag_out = n_env[odf_pkg::ENV_W-1:1];
        if (n_flip) begin
            o_sample = odf_pkg::SAMPLE_W'(0) - mag_out;
        end else if (mag_out[odf_pkg::SAMPLE_W-1]) begin
            o_sample = {1'b0, {(odf_pkg::SAMPLE_W-1){1'b1}}};
        end else begin
            o_sample = mag_out;
        end
    end

    // state write back when an octave-down item leaves the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < odf_pkg::CHANNELS; i++) begin
                r_last_neg[i] <= 1'b0;
                r_cross[i]    <= 1'b0;
                r_flip[i]     <= 1'b0;
                r_env[i]      <= '0;
            end
        end else if (i_update) begin
            r_last_neg[i_ch] <= neg;
            r_cross[i_ch]    <= n_cross;
            r_flip[i_ch]     <= n_flip;
            r_env[i_ch]      <= n_env;
        end
    end

endmodule

`default_nettype wire

// File: design/octave_divider_effect.sv
// Octave divider effect: pass through, octave up, or flip-flop octave down.
// Items pass through an input register, then a result register.
// Throughput: one item per cycle while the receiver does not stall, set by
// the single pass of logic between the two registers with per-channel state
// written back. Reset (synchronous, active low) clears channel state and
// valid flags, loads mode off, 655, 66.
`default_nettype none

module octave_divider_effect (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration write port
    input  wire logic                          i_cfg_we,
    input  wire logic [1:0]                    i_cfg_idx,
    input  wire logic [odf_pkg::COEFF_W-1:0]   i_cfg_wdata,
    // input items
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [odf_pkg::CH_W-1:0]      i_channel,
    input  wire logic signed [odf_pkg::SAMPLE_W-1:0] i_sample_in,
    // result items
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic      [odf_pkg::CH_W-1:0]      o_channel_out,
    output logic signed [odf_pkg::SAMPLE_W-1:0] o_sample_out
);

    localparam int UP_W = odf_pkg::SAMPLE_W + 1;

    odf_pkg::t_cfg cfg;

    logic                          r_in_valid;
    logic [odf_pkg::CH_W-1:0]      r_in_ch;
    logic [odf_pkg::SAMPLE_W-1:0]  r_in_sample;
    logic                          r_out_valid;
    logic [odf_pkg::CH_W-1:0]      r_out_ch;
    logic [odf_pkg::SAMPLE_W-1:0]  r_out_sample;

    logic                          advance;
    logic                          ch_ok;
    logic                          down_update;
    logic [odf_pkg::SAMPLE_W-1:0]  down_sample;
    logic [odf_pkg::SAMPLE_W-1:0]  up_mag;
    logic [UP_W-1:0]               up_val;
    logic [odf_pkg::SAMPLE_W-1:0]  up_sample;
    logic [odf_pkg::SAMPLE_W-1:0]  n_out_sample;

    odf_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // handshake: input register moves on when the result register frees up
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign ch_ok       = int'(r_in_ch) < odf_pkg::CHANNELS;
    assign down_update = advance && ch_ok && (cfg.octave_mode == odf_pkg::MODE_DOWN);

    odf_down u_down (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_update (down_update),
        .i_ch     (r_in_ch),
        .i_sample (r_in_sample),
        .i_cfg    (cfg),
        .o_sample (down_sample)
    );

    // octave up: 2|x| minus full scale, top end saturated
    always_comb begin
        up_mag = odf_pkg::abs_sample(r_in_sample);
        up_val = {up_mag, 1'b0} - (UP_W'(1) << (odf_pkg::SAMPLE_W - 1));
        if (up_mag[odf_pkg::SAMPLE_W-1]) begin
            up_sample = {1'b0, {(odf_pkg::SAMPLE_W-1){1'b1}}};
        end else begin
            up_sample = up_val[odf_pkg::SAMPLE_W-1:0];
        end
    end

    // mode select
    always_comb begin
        n_out_sample = r_in_sample;
        if (ch_ok) begin
            case (cfg.octave_mode)
                odf_pkg::MODE_DOWN: n_out_sample = down_sample;
                odf_pkg::MODE_UP:   n_out_sample = up_sample;
                default:            n_out_sample = r_in_sample;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_ch     <= i_channel;
            r_in_sample <= i_sample_in;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_ch     <= r_in_ch;
            r_out_sample <= n_out_sample;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_channel_out = r_out_ch;
    assign o_sample_out  = r_out_sample;

endmodule

`default_nettype wire

// File: tb/tb_octave_divider_effect.sv
// testbench for the octave divider effect: directed table, then random phases
`timescale 1ns / 100ps

module tb_octave_divider_effect;
    import odf_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic [1:0] REG_NONE    = 2'd3;
    localparam int         STALL_LIMIT = 1000;
    localparam int         PHASES      = 12;
    localparam int         PHASE_ITEMS = 117;

    // one row of the directed table: setting, item, and an optional literal result
    typedef struct {
        logic [1:0]                 mode;
        logic [COEFF_W-1:0]         atk;
        logic [COEFF_W-1:0]         rel;
        logic [CH_W-1:0]            ch;
        logic signed [SAMPLE_W-1:0] smp;
        bit                         known;
        logic signed [SAMPLE_W-1:0] lit;
    } t_step;

    // one result item
    typedef struct {
        logic [CH_W-1:0]            ch;
        logic signed [SAMPLE_W-1:0] smp;
    } t_result;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [1:0]                    i_cfg_idx;
    logic [COEFF_W-1:0]            i_cfg_wdata;
    logic                          i_in_valid;
    logic                          o_in_ready;
    logic [CH_W-1:0]               i_channel;
    logic signed [SAMPLE_W-1:0]    i_sample_in;
    logic                          o_out_valid;
    logic                          i_out_ready;
    logic [CH_W-1:0]               o_channel_out;
    logic signed [SAMPLE_W-1:0]    o_sample_out;

    octave_divider_effect dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_channel     (i_channel),
        .i_sample_in   (i_sample_in),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_channel_out (o_channel_out),
        .o_sample_out  (o_sample_out)
    );

    // mirror of the configuration registers
    logic [1:0]         mode_cfg;
    logic [COEFF_W-1:0] rise_coef;
    logic [COEFF_W-1:0] fall_coef;

    // mirror of the per-channel divider and envelope state
    logic        was_neg   [CHANNELS];
    logic        cross_odd [CHANNELS];
    logic        flip_neg  [CHANNELS];
    logic [31:0] env_level [CHANNELS];

    // waveform generator state per channel
    int unsigned wave_left [CHANNELS];
    int unsigned wave_amp  [CHANNELS];
    bit          wave_neg  [CHANNELS];

    t_result pending_results[$];
    t_step   plan[$];

    int  mismatches;
    int  items_sent;
    int  results_seen;
    int  settings_used;
    int  stall_cycles;
    int  quiet_left;
    bit  calm;

    // clock
    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // expected output for one item, advancing the mirrored state
    function automatic logic signed [SAMPLE_W-1:0] octave_output(
        input logic [CH_W-1:0] ch, input logic signed [SAMPLE_W-1:0] x);
        int          xi;
        int          mag;
        int          y;
        logic        neg;
        logic [31:0] target;
        logic [31:0] env;
        xi = x;
        y  = xi;
        if (ch < CHANNELS) begin
            case (mode_cfg)
                MODE_UP: begin
                    mag = (xi < 0) ? -xi : xi;
                    y   = 2 * mag - 32768;
                end
                MODE_DOWN: begin
                    neg    = (xi < 0);
                    mag    = neg ? -xi : xi;
                    target = 32'(mag) << 1;
                    env    = env_level[ch];
                    // every second sign change flips the output sign
                    if (neg != was_neg[ch]) begin
                        if (cross_odd[ch]) begin
                            flip_neg[ch]  = !flip_neg[ch];
                            cross_odd[ch] = 1'b0;
                        end else begin
                            cross_odd[ch] = 1'b1;
                        end
                    end
                    was_neg[ch] = neg;
                    // envelope moves toward target by a truncated fraction
                    if (target > env)
                        env = env + 32'((64'(rise_coef) * 64'(target - env)) >> 16);
                    else
                        env = env - 32'((64'(fall_coef) * 64'(env - target)) >> 16);
                    env_level[ch] = env;
                    y = int'(env >> 1);
                    if (flip_neg[ch])
                        y = -y;
                end
                default: ;
            endcase
        end
        if (y > 32767)
            y = 32767;
        else if (y < -32768)
            y = -32768;
        return SAMPLE_W'(y);
    endfunction

    // next random sample: mostly a square-like wave with random content
    function automatic logic signed [SAMPLE_W-1:0] next_sample(input logic [CH_W-1:0] ch);
        int unsigned r;
        int unsigned mag;
        r = $urandom_range(0, 99);
        if (r < 8)
            return SAMPLE_W'($urandom);
        if (r < 13) begin
            case ($urandom_range(0, 4))
                0: return 16'sh8000;
                1: return 16'sh7fff;
                2: return 16'sh0000;
                3: return 16'shffff;
                default: return 16'sh0001;
            endcase
        end
        if (wave_left[ch] == 0) begin
            wave_neg[ch]  = !wave_neg[ch];
            wave_left[ch] = $urandom_range(1, 12);
            wave_amp[ch]  = $urandom_range(1, 32767);
        end
        wave_left[ch] = wave_left[ch] - 1;
        mag = $urandom_range(0, wave_amp[ch]);
        return wave_neg[ch] ? SAMPLE_W'(-int'(mag) - 1) : SAMPLE_W'(mag);
    endfunction

    // random coefficient with weight on the extremes
    function automatic logic [COEFF_W-1:0] pick_coeff();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return RESET_ATTACK;
            3: return COEFF_W'($urandom_range(1, 4096));
            default: return COEFF_W'($urandom);
        endcase
    endfunction

    // directed table row
    function automatic void plan_row(input logic [1:0] mode, input logic [COEFF_W-1:0] atk,
                                     input logic [COEFF_W-1:0] rel, input logic [CH_W-1:0] ch,
                                     input logic signed [SAMPLE_W-1:0] smp, input bit known,
                                     input logic signed [SAMPLE_W-1:0] lit);
        t_step s;
        s.mode  = mode;
        s.atk   = atk;
        s.rel   = rel;
        s.ch    = ch;
        s.smp   = smp;
        s.known = known;
        s.lit   = lit;
        plan = {plan, s};
    endfunction

    // one register write, mirrored into the predictor
    task automatic reg_write(input logic [1:0] idx, input logic [COEFF_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_OCTAVE_MODE:   mode_cfg  = data[1:0];
            REG_ATTACK_COEFF:  rise_coef = data;
            REG_RELEASE_COEFF: fall_coef = data;
            default: ;
        endcase
    endtask

    // drain the pipeline, then load a new setting
    task automatic apply_setting(input logic [1:0] mode, input logic [COEFF_W-1:0] atk,
                                 input logic [COEFF_W-1:0] rel);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        reg_write(REG_OCTAVE_MODE, COEFF_W'(mode));
        reg_write(REG_ATTACK_COEFF, atk);
        reg_write(REG_RELEASE_COEFF, rel);
        settings_used++;
    endtask

    // present one item, wait for acceptance, record the expected result
    task automatic send_item(input logic [CH_W-1:0] ch, input logic signed [SAMPLE_W-1:0] smp,
                             input bit known, input logic signed [SAMPLE_W-1:0] lit);
        t_result r;
        logic signed [SAMPLE_W-1:0] predicted;
        if (quiet_left != 0) begin
            quiet_left--;
        end else if (!calm && $urandom_range(0, 39) == 0) begin
            quiet_left = $urandom_range(20, 60);
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat ($urandom_range(0, 17)) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid  <= 1'b1;
        i_channel   <= ch;
        i_sample_in <= smp;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = octave_output(ch, smp);
        r.ch  = ch;
        r.smp = known ? lit : predicted;
        pending_results = {pending_results, r};
        items_sent++;
    endtask

    // receiver stalls in bursts, with quiet stretches
    initial begin
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 11) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge i_clk);
                i_out_ready <= 1'b1;
            end else if (!calm && $urandom_range(0, 39) == 0) begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(20, 60)) @(negedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // compare each result with the oldest expectation
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: channel_out %0d sample_out %0d",
                       o_channel_out, o_sample_out);
                mismatches++;
            end else begin
                exp_r = pending_results.pop_front();
                if (o_channel_out !== exp_r.ch) begin
                    $error("channel_out expected %0d actual %0d", exp_r.ch, o_channel_out);
                    mismatches++;
                end
                if (o_sample_out !== exp_r.smp) begin
                    $error("sample_out expected %0d actual %0d", exp_r.smp, o_sample_out);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("[octave_divider_effect] ERROR");
            $finish;
        end
    end

    // main sequence
    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_wdata  = '0;
        i_in_valid   = 1'b0;
        i_channel    = '0;
        i_sample_in  = '0;
        mismatches   = 0;
        items_sent   = 0;
        results_seen = 0;
        settings_used = 0;
        stall_cycles = 0;
        quiet_left   = 0;
        calm         = 1'b0;
        mode_cfg     = RESET_MODE;
        rise_coef    = RESET_ATTACK;
        fall_coef    = RESET_RELEASE;
        for (int c = 0; c < CHANNELS; c++) begin
            was_neg[c]   = 1'b0;
            cross_odd[c] = 1'b0;
            flip_neg[c]  = 1'b0;
            env_level[c] = '0;
            wave_left[c] = 0;
            wave_amp[c]  = 1;
            wave_neg[c]  = 1'b0;
        end

        // pass through after reset and in the unused mode
        plan_row(MODE_OFF, RESET_ATTACK, RESET_RELEASE, 1'b0, 16'sh8000, 1, 16'sh8000);
        plan_row(MODE_OFF, RESET_ATTACK, RESET_RELEASE, 1'b1, 16'sh7fff, 1, 16'sh7fff);
        plan_row(MODE_OFF, RESET_ATTACK, RESET_RELEASE, 1'b0, 16'sh0000, 1, 16'sh0000);
        plan_row(MODE_UNUSED, RESET_ATTACK, RESET_RELEASE, 1'b1, -16'sd1234, 1, -16'sd1234);
        plan_row(MODE_UNUSED, RESET_ATTACK, RESET_RELEASE, 1'b0, 16'sh7fff, 1, 16'sh7fff);
        // octave up: zero, full scale saturation, both extremes
        plan_row(MODE_UP, RESET_ATTACK, RESET_RELEASE, 1'b0, 16'sh0000, 1, 16'sh8000);
        plan_row(MODE_UP, RESET_ATTACK, RESET_RELEASE, 1'b1, 16'sh8000, 1, 16'sh7fff);
        plan_row(MODE_UP, RESET_ATTACK, RESET_RELEASE, 1'b0, 16'sh7fff, 1, 16'sh7ffe);
        plan_row(MODE_UP, RESET_ATTACK, RESET_RELEASE, 1'b1, 16'sh4000, 1, 16'sh0000);
        plan_row(MODE_UP, RESET_ATTACK, RESET_RELEASE, 1'b0, 16'shffff, 1, 16'sh8002);
        // octave down: crossings on both channels with reset coefficients
        plan_row(MODE_DOWN, RESET_ATTACK, RESET_RELEASE, 1'b0, 16'sd1000, 0, '0);
        plan_row(MODE_DOWN, RESET_ATTACK, RESET_RELEASE, 1'b0, -16'sd1000, 0, '0);
        plan_row(MODE_DOWN, RESET_ATTACK, RESET_RELEASE, 1'b1, 16'sh8000, 0, '0);
        plan_row(MODE_DOWN, RESET_ATTACK, RESET_RELEASE, 1'b0, 16'sd1000, 0, '0);
        plan_row(MODE_DOWN, RESET_ATTACK, RESET_RELEASE, 1'b0, -16'sd1000, 0, '0);
        plan_row(MODE_DOWN, RESET_ATTACK, RESET_RELEASE, 1'b1, 16'sh7fff, 0, '0);
        plan_row(MODE_DOWN, RESET_ATTACK, RESET_RELEASE, 1'b0, 16'sh0000, 0, '0);
        // largest coefficients, envelope close to full scale
        plan_row(MODE_DOWN, 16'hffff, 16'hffff, 1'b0, 16'sh8000, 0, '0);
        plan_row(MODE_DOWN, 16'hffff, 16'hffff, 1'b1, 16'sh8000, 0, '0);
        plan_row(MODE_DOWN, 16'hffff, 16'hffff, 1'b0, 16'sh0000, 0, '0);
        // zero coefficients freeze the envelope
        plan_row(MODE_DOWN, 16'h0000, 16'h0000, 1'b0, 16'sh7fff, 0, '0);
        plan_row(MODE_DOWN, 16'h0000, 16'h0000, 1'b1, -16'sd5, 0, '0);

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (plan[k]) begin
            if (plan[k].mode != mode_cfg || plan[k].atk != rise_coef
                || plan[k].rel != fall_coef)
                apply_setting(plan[k].mode, plan[k].atk, plan[k].rel);
            send_item(plan[k].ch, plan[k].smp, plan[k].known, plan[k].lit);
        end

        // random phases, mostly octave down, the last ones without idling
        for (int p = 0; p < PHASES; p++) begin
            logic [1:0] mode;
            int unsigned r;
            r = $urandom_range(0, 99);
            if (r < 55)
                mode = MODE_DOWN;
            else if (r < 72)
                mode = MODE_UP;
            else if (r < 84)
                mode = MODE_OFF;
            else if (r < 90)
                mode = MODE_UNUSED;
            else
                mode = MODE_DOWN;
            calm = (p >= PHASES - 2);
            apply_setting(mode, pick_coeff(), pick_coeff());
            // a write to the unmapped index must change nothing
            if (p == 0)
                reg_write(REG_NONE, '1);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                logic [CH_W-1:0] ch;
                ch = CH_W'($urandom_range(0, CHANNELS - 1));
                send_item(ch, next_sample(ch), 0, '0);
            end
        end

        // drain and settle
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("run covered %0d items and %0d results under %0d register settings",
                 items_sent, results_seen, settings_used);
        $display("modes down, up, off and unused, coefficients from zero to full scale");
        if (mismatches == 0)
            $display("[octave_divider_effect] OK");
        else
            $display("[octave_divider_effect] ERROR");
        $finish;
    end

endmodule
